>>> design/assert_macros.svh
// Assertion macros shared by the bit reader RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every rising clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/ecbr_pkg.sv
// Shared types, constants and helpers of the configurable-endianness bit reader.
// Used by ecbr_front, ecbr_back and the top level; depends on nothing.
package ecbr_pkg;

	localparam int SOURCE_BYTES   = 4096;
	localparam int ADDR_W         = $clog2(SOURCE_BYTES);
	localparam int LEN_W          = 13;
	localparam int MAX_FIELD_BITS = 32;
	localparam int CNT_W          = 6;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = QPTR_W + 1;

	localparam logic [31:0] M16 = 32'hFFFF0000;
	localparam logic [31:0] M8  = 32'hFF00FF00;
	localparam logic [31:0] M4  = 32'hF0F0F0F0;
	localparam logic [31:0] M2  = 32'hCCCCCCCC;
	localparam logic [31:0] M1  = 32'hAAAAAAAA;

	typedef enum logic [1:0] {
		REQ_LOAD    = 2'd0,
		REQ_READ    = 2'd1,
		REQ_RESTART = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		REG_MSB_FIRST  = 2'd0,
		REG_BIG_ENDIAN = 2'd1,
		REG_SRC_LEN    = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] byte_index;
		logic [7:0]  data_byte;
		logic [5:0]  field_width;
	} req_t;

	typedef struct packed {
		logic [31:0] field_value;
		logic        out_of_data;
		logic [15:0] bits_consumed;
	} res_t;

	typedef struct packed {
		logic             msb_first_bits;
		logic             big_endian_bytes;
		logic [LEN_W-1:0] source_length;
	} cfg_t;

	// Classified request as held in the queue; width already saturated.
	typedef struct packed {
		req_kind_t   op;
		logic [11:0] byte_index;
		logic [7:0]  data_byte;
		logic [5:0]  field_width;
	} cmd_t;

	typedef struct packed {
		logic             err;
		logic [CNT_W-1:0] cnt;
	} back_status_t;

	function automatic logic [31:0] rev32(input logic [31:0] v);
		logic [31:0] t;
		t = ((v & M16) >> 16) | ((v & ~M16) << 16);
		t = ((t & M8) >> 8) | ((t & ~M8) << 8);
		t = ((t & M4) >> 4) | ((t & ~M4) << 4);
		t = ((t & M2) >> 2) | ((t & ~M2) << 2);
		t = ((t & M1) >> 1) | ((t & ~M1) << 1);
		return t;
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

>>> design/ecbr_front.sv
// Front end: takes requests, decodes and saturates them, queues them for the back end.
// Depends on ecbr_pkg.
module ecbr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ecbr_pkg::req_t  req,
	output logic            cmd_valid,
	input  logic            cmd_pop,
	output ecbr_pkg::cmd_t  cmd
);
	import ecbr_pkg::*;

	cmd_t              q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              decoded;
	logic              known;
	logic              push;
	logic              pop;

	always_comb begin
		decoded.op          = REQ_LOAD;
		decoded.byte_index  = req.byte_index;
		decoded.data_byte   = req.data_byte;
		decoded.field_width = (req.field_width > 6'(MAX_FIELD_BITS)) ?
			6'(MAX_FIELD_BITS) : req.field_width;
		known = 1'b1;
		case (req.req_type)
			REQ_LOAD:    decoded.op = REQ_LOAD;
			REQ_READ:    decoded.op = REQ_READ;
			REQ_RESTART: decoded.op = REQ_RESTART;
			default:     known = 1'b0;	// unknown codes are dropped here
		endcase
	end

	assign req_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = req_valid && !req_stall && known;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/ecbr_back.sv
// Back end: source byte memory, bit buffer, refill sequencer and result register.
// Depends on ecbr_pkg.
module ecbr_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ecbr_pkg::cfg_t         cfg,
	input  logic                   cmd_valid,
	output logic                   cmd_pop,
	input  ecbr_pkg::cmd_t         cmd,
	output logic                   res_valid,
	input  logic                   res_stall,
	output ecbr_pkg::res_t         res,
	output ecbr_pkg::back_status_t status
);
	import ecbr_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FETCH, ST_EMIT} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  pos_q;
	logic [31:0]       buf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       consumed_q;
	logic              err_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  got_q;
	logic [31:0]       val_q;
	logic              word_q;
	logic [2:0]        issue_q;
	logic [2:0]        cap_q;
	logic [7:0]        bytes_q [4];
	logic              rd_vld_s1;
	logic [1:0]        rd_slot_s1;
	logic [7:0]        rd_data_s1;
	logic              res_valid_q;
	res_t              res_q;

	logic [7:0]        src_mem [SOURCE_BYTES];

	logic              words;
	logic [2:0]        unit;
	logic [2:0]        unit_f;
	logic [LEN_W-1:0]  src_end;
	logic              refill_ok;
	logic [CNT_W-1:0]  take_n;
	logic [31:0]       chunk;
	logic [31:0]       val_lsb;
	logic [31:0]       val_msb;
	logic              issue_go;
	logic [ADDR_W-1:0] rd_addr;
	logic [31:0]       word_raw;
	logic [31:0]       refill_val;
	logic              res_free;

	always_comb begin
		words     = cfg.msb_first_bits != cfg.big_endian_bytes;
		unit      = words ? 3'd4 : 3'd1;
		unit_f    = word_q ? 3'd4 : 3'd1;
		src_end   = (cfg.source_length > LEN_W'(SOURCE_BYTES)) ?
			LEN_W'(SOURCE_BYTES) : cfg.source_length;
		refill_ok = ({1'b0, pos_q} + (LEN_W+1)'(unit)) <= {1'b0, src_end};

		take_n  = (rem_q < cnt_q) ? rem_q : cnt_q;
		chunk   = buf_q & ~(32'hFFFF_FFFF << take_n);
		val_lsb = val_q | (chunk << got_q);
		val_msb = (val_q << take_n) | (rev32(chunk) >> (6'd32 - take_n));

		issue_go = (state_q == ST_FETCH) && (issue_q < unit_f);
		rd_addr  = pos_q[ADDR_W-1:0] + ADDR_W'(issue_q);

		word_raw = {bytes_q[3], bytes_q[2], bytes_q[1], bytes_q[0]};
		if (word_q) begin
			refill_val = cfg.big_endian_bytes ? swap32(word_raw) : word_raw;
			if (cfg.msb_first_bits) begin
				refill_val = rev32(refill_val);
			end
		end else begin
			refill_val = cfg.msb_first_bits ? rev32({bytes_q[0], 24'd0}) :
				{24'd0, bytes_q[0]};
		end

		res_free = !res_valid_q || !res_stall;
	end

	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign status.err = err_q;
	assign status.cnt = cnt_q;

	// Source store: one write port from load requests, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == REQ_LOAD) begin
			src_mem[cmd.byte_index[ADDR_W-1:0]] <= cmd.data_byte;
		end
		rd_data_s1 <= src_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			buf_q       <= '0;
			cnt_q       <= '0;
			consumed_q  <= '0;
			err_q       <= 1'b0;
			rem_q       <= '0;
			got_q       <= '0;
			val_q       <= '0;
			word_q      <= 1'b0;
			issue_q     <= '0;
			cap_q       <= '0;
			bytes_q     <= '{default: '0};
			rd_vld_s1   <= 1'b0;
			rd_slot_s1  <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			rd_vld_s1  <= issue_go;
			rd_slot_s1 <= issue_q[1:0];
			if (state_q == ST_EMIT && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							REQ_RESTART: begin
								pos_q      <= '0;
								buf_q      <= '0;
								cnt_q      <= '0;
								consumed_q <= '0;
								err_q      <= 1'b0;
							end
							REQ_READ: begin
								rem_q   <= cmd.field_width;
								got_q   <= '0;
								val_q   <= '0;
								state_q <= err_q ? ST_EMIT : ST_RUN;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					if (rem_q == '0) begin
						state_q <= ST_EMIT;
					end else if (cnt_q != '0) begin
						buf_q      <= buf_q >> take_n;
						cnt_q      <= cnt_q - take_n;
						rem_q      <= rem_q - take_n;
						got_q      <= got_q + take_n;
						consumed_q <= consumed_q + 16'(take_n);
						val_q      <= cfg.msb_first_bits ? val_msb : val_lsb;
					end else if (refill_ok) begin
						word_q  <= words;
						issue_q <= '0;
						cap_q   <= '0;
						state_q <= ST_FETCH;
					end else begin
						err_q   <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_FETCH: begin
					if (issue_go) begin
						issue_q <= issue_q + 1'b1;
					end
					if (rd_vld_s1) begin
						bytes_q[rd_slot_s1] <= rd_data_s1;
						cap_q <= cap_q + 1'b1;
					end
					if (cap_q == unit_f) begin
						buf_q   <= refill_val;
						cnt_q   <= word_q ? CNT_W'(32) : CNT_W'(8);
						pos_q   <= pos_q + LEN_W'(unit_f);
						state_q <= ST_RUN;
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						res_q.field_value   <= val_q;
						res_q.out_of_data   <= err_q;
						res_q.bits_consumed <= consumed_q;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> design/endian_configurable_bit_reader.sv
// Top level of the configurable-endianness bit reader: configuration registers,
// front/back instances and checks. Depends on ecbr_pkg, ecbr_front, ecbr_back, assert_macros.svh.
//
// Bit reader over a 4096-byte source store. Requests are byte loads, field reads
// (0 to 32 bits, wider requests clamp to 32) and restarts; only a field read gives a
// result. Requests land in a four-entry queue, so the sender keeps going while the
// back end works or while a result waits, until the queue is full. In the back end a
// load or restart is done from the idle state; a field read drains the buffered
// chunks and refills by byte unit (bit order equals byte order) or by 32-bit word
// unit, fetched byte by byte through the single registered read port of the source
// memory. A read after the error goes straight to its result. After a refill goes
// past source_length the sticky out_of_data flag is set and later reads return zero
// until a restart. Configuration must be written only while the block is idle; the
// block itself does not enforce this.
`include "assert_macros.svh"

module endian_configurable_bit_reader (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  ecbr_pkg::req_t           req,
	output logic                     res_valid,
	input  logic                     res_stall,
	output ecbr_pkg::res_t           res,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [ecbr_pkg::LEN_W-1:0] cfg_data
);
	import ecbr_pkg::*;

	cfg_t         cfg_q;
	logic         cmd_valid;
	logic         cmd_pop;
	cmd_t         cmd;
	back_status_t status;

	// Config writes are always taken; an index past the register list is ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MSB_FIRST:  cfg_q.msb_first_bits   <= cfg_data[0];
				REG_BIG_ENDIAN: cfg_q.big_endian_bytes <= cfg_data[0];
				REG_SRC_LEN:    cfg_q.source_length    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: decode and queue the request.
	ecbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	// Back: memory, bit buffer, refill sequencing, result register.
	ecbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.status    (status)
	);

	// Buffer never holds more than one refill unit.
	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, status.cnt <= CNT_W'(MAX_FIELD_BITS))
	// Error is only raised on an empty buffer, and nothing refills until restart.
	`ASSERT_IMPLIES(a_err_empty, clk, arst_n, status.err, status.cnt == '0)
	// A freshly posted result carries the current sticky flag.
	`ASSERT_IMPLIES(a_res_flag, clk, arst_n, $rose(res_valid), res.out_of_data == status.err)

endmodule
